>>> design/snrt_pkg.sv
// Shared types, constants and helper functions of the sensor node reception tracker.
package snrt_pkg;

    // Sizes of the item fields and of the configuration registers.
    localparam int NODES_DEF  = 6;
    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int PERIOD_W   = 16;
    localparam int TOL_W      = 10;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd60;
    localparam logic [TOL_W-1:0]    TOL_RST    = 10'd50;

    // floor(x / 100) for x below 2^30 is (x * ceil(2^33 / 100)) >> 33.
    localparam int PCT_DIV     = 100;
    localparam int RECIP_SHIFT = 33;
    localparam int RECIP_W     = 27;
    localparam int PROD_W      = PERIOD_W + TOL_W;
    localparam int ALLOW_W     = 20;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV);
    localparam logic [RECIP_W-1:0] PCT_RECIP = RECIP_W'(RECIP_FULL);

    typedef enum logic [1:0] {
        CMD_PACKET = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_PERIOD = 1'b0,
        REG_TOL    = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD,
        ST_WALK,
        ST_LAST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic addr_id;
        logic pkt_upd;
        logic tick_upd;
        logic rec_out;
        logic zero_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic id_ok;
    } dp_stat_t;

    // One node's stored record.
    typedef struct packed {
        logic [BYTE_W-1:0] app_code;
        logic [BYTE_W-1:0] sensor_code;
        logic [BYTE_W-1:0] radio_code;
        logic [VAL_W-1:0]  temp;
        logic [VAL_W-1:0]  humidity;
        logic [VAL_W-1:0]  volt;
        logic [TIME_W-1:0] seen_time;
        logic [CNT_W-1:0]  pkt_count;
        logic [CNT_W-1:0]  miss_count;
        logic [CNT_W-1:0]  window_count;
        logic              window_open;
        logic [CNT_W-1:0]  run_now;
        logic [CNT_W-1:0]  run_best;
    } node_rec_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> design/snrt_ctrl.sv
// Controller state machine of the sensor node reception tracker.
module snrt_ctrl #(
    parameter int NODES = snrt_pkg::NODES_DEF,
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  snrt_pkg::dp_stat_t   stat,
    output snrt_pkg::ctrl_cmd_t  ctl,
    output logic [IDX_W-1:0]     walk_ptr
);
    import snrt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                unique case (stat.cmd)
                    CMD_PACKET, CMD_READ:
                    begin
                        if (stat.id_ok)
                        begin
                            ctl.rd_en   = 1'b1;
                            ctl.addr_id = 1'b1;
                            state_next  = ST_UPD;
                        end
                        else
                        begin
                            ctl.zero_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    CMD_TICK:
                    begin
                        ptr_next   = '0;
                        state_next = ST_WALK;
                    end
                    default:
                    begin
                        ctl.zero_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                endcase
            end
            ST_UPD:
            begin
                ctl.rec_out = 1'b1;
                ctl.pkt_upd = (stat.cmd == CMD_PACKET);
                state_next  = ST_IDLE;
            end
            ST_WALK:
            begin
                // Read node ptr while the node read last cycle is updated.
                ctl.rd_en    = 1'b1;
                ctl.tick_upd = (ptr_reg != '0);
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                ctl.tick_upd = 1'b1;
                ctl.zero_out = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign walk_ptr = ptr_reg;

endmodule

>>> design/snrt_dp.sv
// Datapath of the sensor node reception tracker: item latch, node table and result word.
module snrt_dp #(
    parameter int NODES = snrt_pkg::NODES_DEF,
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  snrt_pkg::ctrl_cmd_t  ctl,
    output snrt_pkg::dp_stat_t   stat,
    input  logic [IDX_W-1:0]     walk_ptr,
    input  logic [15:0]          report_period_s,
    input  logic [9:0]           tolerance_pct,
    input  logic [1:0]           cmd,
    input  logic [7:0]           node_id,
    input  logic [7:0]           app_code,
    input  logic [7:0]           sensor_status,
    input  logic [7:0]           radio_status,
    input  logic [15:0]          temperature,
    input  logic [15:0]          humidity,
    input  logic [15:0]          voltage,
    input  logic [31:0]          now_seconds,
    output logic                 done,
    output logic                 status,
    output snrt_pkg::node_rec_t  res_rec
);
    import snrt_pkg::*;

    localparam int MUL_W = PROD_W + RECIP_W;

    // Latched item.
    cmd_t               cmd_reg;
    logic [BYTE_W-1:0]  node_id_reg;
    logic [BYTE_W-1:0]  app_reg;
    logic [BYTE_W-1:0]  sensor_reg;
    logic [BYTE_W-1:0]  radio_reg;
    logic [VAL_W-1:0]   temp_reg;
    logic [VAL_W-1:0]   hum_reg;
    logic [VAL_W-1:0]   volt_reg;
    logic [TIME_W-1:0]  now_reg;

    // Allowance pipeline, always running from the configuration registers.
    logic [PROD_W-1:0]  prod_reg;
    logic [MUL_W-1:0]   recip_prod;
    logic [ALLOW_W-1:0] quot_reg;
    logic [ALLOW_W-1:0] allow_reg;

    // Node table.
    node_rec_t          mem_q [NODES];
    node_rec_t          rdata_reg;
    logic               rvalid_reg;
    logic [NODES-1:0]   valid_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr_reg;
    logic               we;
    node_rec_t          cur_rec;
    node_rec_t          pkt_rec;
    node_rec_t          tick_rec;
    node_rec_t          wdata;
    logic               overdue;
    logic [CNT_W-1:0]   run_inc;
    logic               id_ok;
    logic               bad_id;

    // Result word.
    node_rec_t          res_rec_reg;
    logic               status_reg;
    logic               done_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= cmd_t'(cmd);
            node_id_reg <= node_id;
            app_reg     <= app_code;
            sensor_reg  <= sensor_status;
            radio_reg   <= radio_status;
            temp_reg    <= temperature;
            hum_reg     <= humidity;
            volt_reg    <= voltage;
            now_reg     <= now_seconds;
        end
    end

    assign recip_prod = MUL_W'(prod_reg) * MUL_W'(PCT_RECIP);

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(report_period_s) * PROD_W'(tolerance_pct);
        quot_reg  <= ALLOW_W'(recip_prod >> RECIP_SHIFT);
        allow_reg <= ALLOW_W'(report_period_s) + quot_reg;
    end

    assign id_ok  = ({1'b0, node_id_reg} < 9'(NODES));
    assign bad_id = ((cmd_reg == CMD_PACKET) || (cmd_reg == CMD_READ)) && !id_ok;
    assign stat.cmd   = cmd_reg;
    assign stat.id_ok = id_ok;

    assign rd_addr = ctl.addr_id ? node_id_reg[IDX_W-1:0] : walk_ptr;
    assign we      = ctl.pkt_upd || ctl.tick_upd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[wr_addr_reg] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg   <= mem_q[rd_addr];
            wr_addr_reg <= rd_addr;
        end
    end

    // An entry that was never written reads as the all-zero reset record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign cur_rec = rvalid_reg ? rdata_reg : '0;

    always_comb
    begin
        pkt_rec             = cur_rec;
        pkt_rec.app_code    = app_reg;
        pkt_rec.sensor_code = sensor_reg;
        pkt_rec.radio_code  = radio_reg;
        pkt_rec.temp        = temp_reg;
        pkt_rec.humidity    = hum_reg;
        pkt_rec.volt        = volt_reg;
        pkt_rec.seen_time   = now_reg;
        pkt_rec.pkt_count   = sat_inc(cur_rec.pkt_count);
        if (cur_rec.window_open)
        begin
            pkt_rec.window_open = 1'b0;
            pkt_rec.run_now     = '0;
        end
    end

    assign overdue = ({1'b0, now_reg} >
                      ({1'b0, cur_rec.seen_time} + (TIME_W + 1)'(allow_reg)));
    assign run_inc = sat_inc(cur_rec.run_now);

    always_comb
    begin
        tick_rec = cur_rec;
        if (overdue)
        begin
            tick_rec.miss_count = sat_inc(cur_rec.miss_count);
            if (!cur_rec.window_open)
            begin
                tick_rec.window_count = sat_inc(cur_rec.window_count);
                tick_rec.window_open  = 1'b1;
            end
            tick_rec.run_now = run_inc;
            if (run_inc > cur_rec.run_best)
            begin
                tick_rec.run_best = run_inc;
            end
        end
    end

    assign wdata = ctl.pkt_upd ? pkt_rec : tick_rec;

    always_ff @(posedge clk)
    begin
        priority if (ctl.rec_out)
        begin
            res_rec_reg <= ctl.pkt_upd ? pkt_rec : cur_rec;
            status_reg  <= 1'b0;
        end
        else if (ctl.zero_out)
        begin
            res_rec_reg <= '0;
            status_reg  <= bad_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.rec_out || ctl.zero_out;
        end
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign res_rec = res_rec_reg;

endmodule

>>> design/sensor_node_reception_tracker_core.sv
// Top level of the sensor node reception tracker: configuration registers and core wiring.
// Busy spans the lookup and update states for a packet or read of a valid node, the
// lookup state alone for a bad node id or an unused command, and for a tick the lookup,
// walk (one node per cycle via the table's single read port) and last states; the result
// follows in the next cycle. Throughput: a new word is taken when that result shows.
// Reset clears the node table through per-node valid bits at once and loads the period
// and tolerance registers with 60 and 50; the receiver cannot stall results.
module sensor_node_reception_tracker_core #(
    parameter int NODES = snrt_pkg::NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [snrt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Item port.
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          cmd,
    input  logic [7:0]          node_id,
    input  logic signed [7:0]   app_code,
    input  logic [7:0]          sensor_status,
    input  logic [7:0]          radio_status,
    input  logic signed [15:0]  temperature,
    input  logic signed [15:0]  humidity,
    input  logic [15:0]         voltage,
    input  logic [31:0]         now_seconds,
    // Result port.
    output logic                done,
    output logic                status,
    output logic signed [7:0]   out_app_code,
    output logic [7:0]          out_sensor_status,
    output logic [7:0]          out_radio_status,
    output logic signed [15:0]  out_temperature,
    output logic signed [15:0]  out_humidity,
    output logic [15:0]         out_voltage,
    output logic [31:0]         last_seen,
    output logic [31:0]         packets_received,
    output logic [31:0]         misses,
    output logic [31:0]         miss_windows,
    output logic [31:0]         longest_run
);
    import snrt_pkg::*;

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    logic [PERIOD_W-1:0] period_reg;
    logic [TOL_W-1:0]    tol_reg;
    reg_idx_t            reg_idx;
    ctrl_cmd_t           ctl;
    dp_stat_t            stat;
    logic [IDX_W-1:0]    walk_ptr;
    node_rec_t           res_rec;

    // The register index is address bit 2; the port never waits.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            tol_reg    <= TOL_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_PERIOD: period_reg <= pwdata[PERIOD_W-1:0];
                REG_TOL:    tol_reg    <= pwdata[TOL_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERIOD: prdata = DATA_W'(period_reg);
            REG_TOL:    prdata = DATA_W'(tol_reg);
            default:    prdata = '0;
        endcase
    end

    // The controller sequences each word; the datapath holds the node table and
    // computes the overdue allowance continuously from the two registers.
    snrt_ctrl #(.NODES(NODES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .stat     (stat),
        .ctl      (ctl),
        .walk_ptr (walk_ptr)
    );

    snrt_dp #(.NODES(NODES)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .walk_ptr        (walk_ptr),
        .report_period_s (period_reg),
        .tolerance_pct   (tol_reg),
        .cmd             (cmd),
        .node_id         (node_id),
        .app_code        (app_code),
        .sensor_status   (sensor_status),
        .radio_status    (radio_status),
        .temperature     (temperature),
        .humidity        (humidity),
        .voltage         (voltage),
        .now_seconds     (now_seconds),
        .done            (done),
        .status          (status),
        .res_rec         (res_rec)
    );

    assign out_app_code      = res_rec.app_code;
    assign out_sensor_status = res_rec.sensor_code;
    assign out_radio_status  = res_rec.radio_code;
    assign out_temperature   = res_rec.temp;
    assign out_humidity      = res_rec.humidity;
    assign out_voltage       = res_rec.volt;
    assign last_seen         = res_rec.seen_time;
    assign packets_received  = res_rec.pkt_count;
    assign misses            = res_rec.miss_count;
    assign miss_windows      = res_rec.window_count;
    assign longest_run       = res_rec.run_best;

endmodule

>>> design/snrt_chk.sv
// Port-level assertion checker of the sensor node reception tracker and its bind.
module snrt_chk #(
    parameter int NODES = snrt_pkg::NODES_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic [1:0]   cmd,
    input logic [7:0]   node_id,
    input logic         done,
    input logic         status,
    input logic [7:0]   out_app_code,
    input logic [7:0]   out_sensor_status,
    input logic [7:0]   out_radio_status,
    input logic [15:0]  out_temperature,
    input logic [15:0]  out_humidity,
    input logic [15:0]  out_voltage,
    input logic [31:0]  last_seen,
    input logic [31:0]  packets_received,
    input logic [31:0]  misses,
    input logic [31:0]  miss_windows,
    input logic [31:0]  longest_run
);
    import snrt_pkg::*;

    // A result is shown only once the block is ready for the next word.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // A tick walks every node once before its result appears.
    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_TICK)) |=> ##(NODES + 2) (done && !status))
        else $error("tick result missing at expected cycle");

    a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd == CMD_PACKET) || (cmd == CMD_READ))
         && ({1'b0, node_id} >= 9'(NODES))) |=> ##1 (done && status))
        else $error("bad node id not reported");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ((out_app_code == '0) && (out_sensor_status == '0)
            && (out_radio_status == '0) && (out_temperature == '0)
            && (out_humidity == '0) && (out_voltage == '0) && (last_seen == '0)
            && (packets_received == '0) && (misses == '0) && (miss_windows == '0)
            && (longest_run == '0)))
        else $error("error result carries a record");

endmodule

bind sensor_node_reception_tracker_core snrt_chk #(.NODES(NODES)) u_snrt_chk (.*);
